// ----- src/led_command_parser_assert.svh -----
// Assertion macros shared by the checker of the LED command parser.
`ifndef LED_COMMAND_PARSER_ASSERT_SVH
`define LED_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while reset is active.
`define LCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("LED command parser check failed");

// Next-cycle implication, sampled on clk and quiet while reset is active.
`define LCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("LED command parser check failed");

`endif

// ----- src/lcp_pkg.sv -----
// Types and constants of the LED command parser.
package lcp_pkg;

	localparam int KW_COUNT   = 5;
	localparam int KW_MAX_LEN = 4;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NUL  = 8'h00;

	// Keyword text, unused tail positions hold NUL.
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{8'h48, 8'h45, 8'h4C, 8'h50},  // HELP
		'{8'h47, 8'h45, 8'h54, CH_NUL}, // GET
		'{8'h53, 8'h45, 8'h54, CH_NUL}, // SET
		'{8'h43, 8'h4C, 8'h52, CH_NUL}, // CLR
		'{8'h49, 8'h4E, 8'h56, CH_NUL}  // INV
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd3, 3'd3, 3'd3};

	// Commands, in matcher priority order.
	typedef enum logic [2:0] {
		CMD_HELP = 3'd0,
		CMD_GET  = 3'd1,
		CMD_SET  = 3'd2,
		CMD_CLR  = 3'd3,
		CMD_INV  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DIGIT = 2'd1,
		PH_CR    = 2'd2
	} phase_t;

	localparam logic [1:0] RESP_NONE = 2'd0;
	localparam logic [1:0] RESP_HELP = 2'd1;
	localparam logic [1:0] RESP_LED  = 2'd2;
	localparam logic [1:0] RESP_ERR  = 2'd3;

	// Outcome of feeding one byte to the keyword matchers.
	typedef struct packed {
		logic hit;
		cmd_t cmd;
	} kw_hit_t;

endpackage

// ----- src/lcp_kw_match.sv -----
// Five prioritized keyword matchers with their position registers.
module lcp_kw_match (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            feed,
	input  logic [7:0]      rx_byte,
	output lcp_pkg::kw_hit_t result
);

	logic [2:0] pos_q [lcp_pkg::KW_COUNT];
	logic [2:0] pos_d [lcp_pkg::KW_COUNT];

	// Matchers are tried in priority order; the first full match hides the byte from the rest.
	always_comb begin
		logic [2:0] next_pos;
		next_pos = 3'd0;
		result.hit = 1'b0;
		result.cmd = lcp_pkg::CMD_HELP;
		for (int k = 0; k < lcp_pkg::KW_COUNT; k++) begin
			pos_d[k] = pos_q[k];
			if (!result.hit) begin
				next_pos = pos_q[k] + 3'd1;
				if (pos_q[k] >= lcp_pkg::KW_LEN[k] ||
				    rx_byte != lcp_pkg::KW_TEXT[k][pos_q[k][1:0]]) begin
					pos_d[k] = 3'd0;
				end else if (next_pos >= lcp_pkg::KW_LEN[k]) begin
					pos_d[k] = 3'd0;
					result.hit = 1'b1;
					result.cmd = lcp_pkg::cmd_t'(3'(k));
				end else begin
					pos_d[k] = next_pos;
				end
			end
		end
	end

	// Positions advance only when a byte is fed while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lcp_pkg::KW_COUNT; k++) begin
				pos_q[k] <= 3'd0;
			end
		end else if (feed) begin
			for (int k = 0; k < lcp_pkg::KW_COUNT; k++) begin
				pos_q[k] <= pos_d[k];
			end
		end
	end

endmodule

// ----- src/led_command_parser.sv -----
// LED command parser: two-register pipeline that decodes one received byte per transfer.
// A byte accepted into the input register is decoded there, and its result is written to
// the result register when the input stage moves; the result register offers it on the outputs.
// Throughput: one byte per cycle; the input register and the result register both move
// whenever the result register is empty or its result is taken in that cycle.
// Reset clears the parse phase, keyword positions, pending command, digit and LED levels.
module led_command_parser #(
	parameter int LED_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] echo_byte,
	output logic [1:0] response,
	output logic [2:0] led_index,
	output logic       led_level,
	output logic [7:0] led_outputs
);

	logic              valid_s1;
	logic [7:0]        rx_s1;
	logic              out_free;
	logic              s1_move;
	lcp_pkg::phase_t   phase_q;
	lcp_pkg::phase_t   phase_d;
	lcp_pkg::cmd_t     pending_q;
	logic [7:0]        digit_q;
	logic [7:0]        levels_q;
	logic [7:0]        levels_d;
	logic [7:0]        led_bit;
	logic [1:0]        resp_d;
	logic [2:0]        idx_d;
	logic              lvl_d;
	lcp_pkg::kw_hit_t  kw;
	logic              out_valid_q;
	logic [7:0]        echo_q;
	logic [1:0]        resp_q;
	logic [2:0]        idx_q;
	logic              lvl_q;
	logic [7:0]        leds_q;

	// Handshake: the input stage moves when the result register is free or being emptied.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_s1 <= rx_byte;
		end
	end

	lcp_kw_match u_kw_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (s1_move && phase_q == lcp_pkg::PH_IDLE),
		.rx_byte (rx_s1),
		.result  (kw)
	);

	// Next parse phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			lcp_pkg::PH_IDLE: begin
				if (kw.hit) begin
					phase_d = (kw.cmd == lcp_pkg::CMD_HELP) ? lcp_pkg::PH_CR : lcp_pkg::PH_DIGIT;
				end
			end
			lcp_pkg::PH_DIGIT: begin
				phase_d = lcp_pkg::PH_CR;
			end
			lcp_pkg::PH_CR: begin
				phase_d = lcp_pkg::PH_IDLE;
			end
			default: begin
				phase_d = lcp_pkg::PH_IDLE;
			end
		endcase
	end

	assign led_bit = 8'd1 << digit_q[2:0];

	// Response and LED update for the byte in the input register.
	always_comb begin
		resp_d   = lcp_pkg::RESP_NONE;
		idx_d    = 3'd0;
		lvl_d    = 1'b0;
		levels_d = levels_q;
		unique case (phase_q)
			lcp_pkg::PH_IDLE: begin
				if (!kw.hit && rx_s1 == lcp_pkg::CH_CR) begin
					resp_d = lcp_pkg::RESP_ERR;
				end
			end
			lcp_pkg::PH_CR: begin
				priority if (rx_s1 != lcp_pkg::CH_CR) begin
					resp_d = lcp_pkg::RESP_ERR;
				end else if (pending_q == lcp_pkg::CMD_HELP) begin
					resp_d = lcp_pkg::RESP_HELP;
				end else if (digit_q >= 8'(LED_COUNT) || digit_q > 8'd7) begin
					resp_d = lcp_pkg::RESP_ERR;
				end else begin
					unique case (pending_q)
						lcp_pkg::CMD_SET: levels_d = levels_q | led_bit;
						lcp_pkg::CMD_CLR: levels_d = levels_q & ~led_bit;
						lcp_pkg::CMD_INV: levels_d = levels_q ^ led_bit;
						default:          levels_d = levels_q;
					endcase
					resp_d = lcp_pkg::RESP_LED;
					idx_d  = digit_q[2:0];
					lvl_d  = levels_d[digit_q[2:0]];
				end
			end
			default: begin
				resp_d = lcp_pkg::RESP_NONE;
			end
		endcase
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lcp_pkg::PH_IDLE;
			pending_q <= lcp_pkg::CMD_HELP;
			digit_q   <= 8'd0;
			levels_q  <= 8'd0;
		end else if (s1_move) begin
			phase_q  <= phase_d;
			levels_q <= levels_d;
			if (phase_q == lcp_pkg::PH_IDLE && kw.hit) begin
				pending_q <= kw.cmd;
			end
			if (phase_q == lcp_pkg::PH_DIGIT) begin
				digit_q <= rx_s1 - lcp_pkg::CH_ZERO;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			echo_q <= rx_s1;
			resp_q <= resp_d;
			idx_q  <= idx_d;
			lvl_q  <= lvl_d;
			leds_q <= levels_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign echo_byte   = echo_q;
	assign response    = resp_q;
	assign led_index   = idx_q;
	assign led_level   = lvl_q;
	assign led_outputs = leds_q;

endmodule

// ----- src/lcp_checker.sv -----
// Port-level checker of the LED command parser and its bind.
`include "led_command_parser_assert.svh"

module lcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] echo_byte,
	input logic [1:0] response,
	input logic [2:0] led_index,
	input logic       led_level,
	input logic [7:0] led_outputs
);

	// A stalled result keeps its contents.
	`LCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(echo_byte) && $stable(response) && $stable(led_outputs))

	// A LED report agrees with the full LED vector.
	`LCP_ASSERT_NOW(a_led_report, out_valid && response == lcp_pkg::RESP_LED,
		led_outputs[led_index] == led_level)

	// Index and level are zero unless a LED is reported.
	`LCP_ASSERT_NOW(a_no_report, out_valid && response != lcp_pkg::RESP_LED,
		led_index == 3'd0 && led_level == 1'b0)

	// Help and LED reports complete only on a carriage return.
	`LCP_ASSERT_NOW(a_ok_on_cr,
		out_valid && (response == lcp_pkg::RESP_HELP || response == lcp_pkg::RESP_LED),
		echo_byte == lcp_pkg::CH_CR)

	// The input is held off only while a result waits on a stalled receiver.
	`LCP_ASSERT_NOW(a_stall_when_full, in_stall, out_valid && out_stall)

endmodule

bind led_command_parser lcp_checker u_lcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.echo_byte   (echo_byte),
	.response    (response),
	.led_index   (led_index),
	.led_level   (led_level),
	.led_outputs (led_outputs)
);
